// ----- hw/rtl/whist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted 2-D histogram package
// Item types, status and action codes, register indexes and constants.
// ----------------------------------------------------------------------------
package whist_pkg;

    typedef enum logic {
        ACT_DEPOSIT = 1'b0,
        ACT_READ    = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_DEPOSITED  = 2'd0,
        ST_OUTSIDE    = 2'd1,
        ST_READ_VALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_X_MIN   = 3'd0,
        REG_X_SCALE = 3'd1,
        REG_Y_MIN   = 3'd2,
        REG_Y_SCALE = 3'd3,
        REG_CELLS_X = 3'd4,
        REG_CELLS_Y = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_LOOK,
        S_WRITE
    } hist_state_t;

    typedef struct packed {
        action_t            action;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [23:0]        mass;
        logic [15:0]        metal_fraction;
        logic [5:0]         read_column;
        logic [5:0]         read_row;
    } hist_in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] cell_count;
        logic [47:0] cell_mass;
        logic [47:0] cell_metal;
    } hist_out_t;

    typedef struct packed {
        logic [31:0] count;
        logic [47:0] mass;
        logic [47:0] metal;
    } cell_t;

    typedef struct packed {
        logic        in_grid;
        logic [15:0] bin;
    } bin_t;

    // round(2^16 * 0.0122 / 8.65e-3)
    localparam logic [16:0] METAL_K = 17'd92432;

    localparam logic signed [15:0] X_MIN_RST   = -16'sd512;
    localparam logic [15:0]        X_SCALE_RST = 16'd1638;
    localparam logic signed [15:0] Y_MIN_RST   = 16'sd512;
    localparam logic [15:0]        Y_SCALE_RST = 16'd2730;
    localparam logic [6:0]         CELLS_RST   = 7'd64;

endpackage

// ----- hw/rtl/weighted_2d_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted 2-D histogram
// Grid of cells holding saturating count, mass and scaled metal sums.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A deposit bins the
//   point and updates one cell if it lies in the grid; a read returns one cell's sums.
//   Each item gives one result on result, marked by done for one cycle.
//   done is registered from the write-back state that follows multiply
//   and look-up. A new item is taken only after write-back: the cell store
//   has a single read-modify-write path (multiply, look-up, write-back) used per item.
//   Configuration: cfg_index/cfg_data written when cfg_valid is high;
//   cfg_ready is always high. Write registers only while idle.
//   Reset: registers return to their defaults and a clearing pass zeroes
//   the store, one cell a cycle, over all MAX_COLUMNS*MAX_ROWS cells (4096 by
//   default); busy stays high for its length.
//   The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module weighted_2d_histogram
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  whist_pkg::hist_in_t   request,
    output logic                  done,
    output whist_pkg::hist_out_t  result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import whist_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    hist_state_t state_reg, state_next;

    logic signed [15:0] x_min_reg, y_min_reg;
    logic [15:0]        x_scale_reg, y_scale_reg;
    logic [6:0]         cells_x_reg, cells_y_reg;
    logic [15:0]        lim_x, lim_y;

    logic          accept, mul_en, look_en, write_ph, clear_ph, clear_last;
    logic [AW-1:0] clr_addr_reg;

    hist_in_t      req_reg;
    logic [39:0]   mf_reg;
    logic [56:0]   mfk;
    logic [24:0]   met_reg;
    bin_t          bin_x, bin_y;

    logic          look_ok;
    logic          ok_reg;
    logic [AW-1:0] look_idx, dep_idx, rd_idx, idx_reg;

    cell_t         mem [DEPTH];
    cell_t         rdata_reg;
    cell_t         wdata;
    logic [AW-1:0] waddr;
    logic          we;

    logic [48:0]   mass_sum, metal_sum;
    cell_t         upd;

    hist_out_t     result_reg, result_next;
    logic          done_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg   <= X_MIN_RST;
            x_scale_reg <= X_SCALE_RST;
            y_min_reg   <= Y_MIN_RST;
            y_scale_reg <= Y_SCALE_RST;
            cells_x_reg <= CELLS_RST;
            cells_y_reg <= CELLS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_MIN:   x_min_reg   <= cfg_data;
                REG_X_SCALE: x_scale_reg <= cfg_data;
                REG_Y_MIN:   y_min_reg   <= cfg_data;
                REG_Y_SCALE: y_scale_reg <= cfg_data;
                REG_CELLS_X: cells_x_reg <= cfg_data[6:0];
                REG_CELLS_Y: cells_y_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign lim_x = (16'(cells_x_reg) < 16'(MAX_COLUMNS)) ? 16'(cells_x_reg) : 16'(MAX_COLUMNS);
    assign lim_y = (16'(cells_y_reg) < 16'(MAX_ROWS)) ? 16'(cells_y_reg) : 16'(MAX_ROWS);

    // sequencer
    assign clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clear_last) state_next = S_IDLE;
            S_IDLE:  if (start)      state_next = S_MUL;
            S_MUL:   state_next = S_LOOK;
            S_LOOK:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        accept   = 1'b0;
        mul_en   = 1'b0;
        look_en  = 1'b0;
        write_ph = 1'b0;
        clear_ph = 1'b0;
        case (state_reg)
            S_CLEAR: clear_ph = 1'b1;
            S_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            S_MUL:   mul_en   = 1'b1;
            S_LOOK:  look_en  = 1'b1;
            S_WRITE: write_ph = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= write_ph;
            if (clear_ph)
                clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        if (mul_en)
            mf_reg <= 40'(req_reg.mass) * 40'(req_reg.metal_fraction);
        if (look_en)
        begin
            met_reg <= mfk[56:32];
            ok_reg  <= look_ok;
            idx_reg <= look_idx;
        end
        if (write_ph)
            result_reg <= result_next;
    end

    assign mfk = 57'(mf_reg) * 57'(METAL_K);

    whist_bin u_bin_x
    (
        .clk   (clk),
        .en    (mul_en),
        .coord (req_reg.x_coord),
        .lo    (x_min_reg),
        .scale (x_scale_reg),
        .limit (lim_x),
        .bin   (bin_x)
    );

    whist_bin u_bin_y
    (
        .clk   (clk),
        .en    (mul_en),
        .coord (req_reg.y_coord),
        .lo    (y_min_reg),
        .scale (y_scale_reg),
        .limit (lim_y),
        .bin   (bin_y)
    );

    assign dep_idx = AW'(AW'(bin_x.bin) * AW'(MAX_ROWS)) + AW'(bin_y.bin);
    assign rd_idx  = AW'(AW'(req_reg.read_column) * AW'(MAX_ROWS)) + AW'(req_reg.read_row);

    always_comb
    begin
        if (req_reg.action == ACT_READ)
        begin
            look_ok  = (11'(req_reg.read_column) < 11'(MAX_COLUMNS))
                    && (11'(req_reg.read_row) < 11'(MAX_ROWS));
            look_idx = rd_idx;
        end
        else
        begin
            look_ok  = bin_x.in_grid && bin_y.in_grid;
            look_idx = dep_idx;
        end
    end

    // cell store
    assign we    = clear_ph || (write_ph && ok_reg && (req_reg.action == ACT_DEPOSIT));
    assign waddr = clear_ph ? clr_addr_reg : idx_reg;
    assign wdata = clear_ph ? cell_t'('0) : upd;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (look_en)
            rdata_reg <= mem[look_idx];
    end

    assign mass_sum  = {1'b0, rdata_reg.mass} + 49'(req_reg.mass);
    assign metal_sum = {1'b0, rdata_reg.metal} + 49'(met_reg);

    always_comb
    begin
        upd.count = (rdata_reg.count == '1) ? rdata_reg.count : rdata_reg.count + 32'd1;
        upd.mass  = mass_sum[48] ? '1 : mass_sum[47:0];
        upd.metal = metal_sum[48] ? '1 : metal_sum[47:0];
    end

    always_comb
    begin
        result_next            = '0;
        result_next.status     = ST_OUTSIDE;
        if (ok_reg)
        begin
            if (req_reg.action == ACT_READ)
            begin
                result_next.status     = ST_READ_VALID;
                result_next.cell_count = rdata_reg.count;
                result_next.cell_mass  = rdata_reg.mass;
                result_next.cell_metal = rdata_reg.metal;
            end
            else
                result_next.status = ST_DEPOSITED;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/whist_bin.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted 2-D histogram axis binner
// Registered offset-times-scale product, floor to bin and range check.
// ----------------------------------------------------------------------------
module whist_bin
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [15:0]   coord,
    input  logic signed [15:0]   lo,
    input  logic [15:0]          scale,
    input  logic [15:0]          limit,
    output whist_pkg::bin_t      bin
);
    import whist_pkg::*;

    logic [16:0] off;
    logic        neg_reg;
    logic [31:0] prod_reg;

    assign off = {coord[15], coord} - {lo[15], lo};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= off[16];
            prod_reg <= 32'(off[15:0]) * 32'(scale);
        end
    end

    always_comb
    begin
        bin.bin     = prod_reg[31:16];
        bin.in_grid = !neg_reg && (prod_reg[31:16] < limit);
    end

endmodule

// ----- tb/sv/whist_sb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted 2-D histogram scoreboard
// Keeps its own copy of the grid registers and of the three cell stores,
// works out the result of every accepted item and checks the block's results
// against them in order.
// ----------------------------------------------------------------------------
package whist_sb_pkg;

    import whist_pkg::*;

    class hist_scoreboard #(int COLS = 64, int ROWS = 64);

        bit [31:0]          count_mem [COLS*ROWS];
        bit [47:0]          mass_mem  [COLS*ROWS];
        bit [47:0]          metal_mem [COLS*ROWS];
        logic signed [15:0] x_min;
        logic signed [15:0] y_min;
        logic [15:0]        x_scale;
        logic [15:0]        y_scale;
        logic [6:0]         cells_x;
        logic [6:0]         cells_y;
        hist_out_t          pending_q [$];
        int                 mismatches;
        int                 last_col;
        int                 last_row;

        function new();
            x_min   = -16'sd512;
            x_scale = 16'd1638;
            y_min   = 16'sd512;
            y_scale = 16'd2730;
            cells_x = 7'd64;
            cells_y = 7'd64;
        endfunction

        function void set_register(reg_index_t idx, logic [15:0] data);
            case (idx)
                REG_X_MIN:   x_min = data;
                REG_X_SCALE: x_scale = data;
                REG_Y_MIN:   y_min = data;
                REG_Y_SCALE: y_scale = data;
                REG_CELLS_X: cells_x = data[6:0];
                REG_CELLS_Y: cells_y = data[6:0];
                default: ;
            endcase
        endfunction

        // floor((coord - lo) * scale / 2^16) in bins; rejects negative offsets and bins past the limit
        function bit find_bin(logic signed [15:0] coord, logic signed [15:0] lo,
                              logic [15:0] scale, logic [6:0] cells, int limit,
                              output int bin);
            logic [16:0] offset;
            logic [31:0] product;
            int          lim;
            offset = {coord[15], coord} - {lo[15], lo};
            lim    = (cells < limit) ? int'(cells) : limit;
            bin    = 0;
            if (offset[16])
                return 1'b0;
            product = {16'b0, offset[15:0]} * {16'b0, scale};
            bin     = int'(product[31:16]);
            return bin < lim;
        endfunction

        function void note_request(hist_in_t req);
            hist_out_t   want;
            int          col;
            int          row;
            int          idx;
            bit [63:0]   metal_inc;
            bit [48:0]   mass_sum;
            bit [63:0]   metal_sum;
            want = '0;
            if (req.action == ACT_READ) begin
                col = req.read_column;
                row = req.read_row;
                if (col >= COLS || row >= ROWS) begin
                    want.status = ST_OUTSIDE;
                end
                else begin
                    idx             = col * ROWS + row;
                    want.status     = ST_READ_VALID;
                    want.cell_count = count_mem[idx];
                    want.cell_mass  = mass_mem[idx];
                    want.cell_metal = metal_mem[idx];
                end
            end
            else if (!find_bin(req.x_coord, x_min, x_scale, cells_x, COLS, col) ||
                     !find_bin(req.y_coord, y_min, y_scale, cells_y, ROWS, row)) begin
                want.status = ST_OUTSIDE;
            end
            else begin
                idx = col * ROWS + row;
                // gain is round(2^16 * 0.0122 / 8.65e-3)
                metal_inc = (64'(req.mass) * 64'(req.metal_fraction) * 64'd92432) >> 32;
                if (count_mem[idx] != 32'hFFFF_FFFF)
                    count_mem[idx] = count_mem[idx] + 32'd1;
                mass_sum       = {1'b0, mass_mem[idx]} + 49'(req.mass);
                mass_mem[idx]  = mass_sum[48] ? '1 : mass_sum[47:0];
                metal_sum      = 64'(metal_mem[idx]) + metal_inc;
                metal_mem[idx] = (metal_sum > 64'hFFFF_FFFF_FFFF) ? '1 : metal_sum[47:0];
                want.status    = ST_DEPOSITED;
                last_col       = col;
                last_row       = row;
            end
            pending_q.push_back(want);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        endtask

        task check_result(hist_out_t got);
            hist_out_t want;
            if (pending_q.size() == 0) begin
                report("unexpected result, status", got.status, '0);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.cell_count !== want.cell_count)
                report("cell_count", got.cell_count, want.cell_count);
            if (got.cell_mass !== want.cell_mass)
                report("cell_mass", got.cell_mass, want.cell_mass);
            if (got.cell_metal !== want.cell_metal)
                report("cell_metal", got.cell_metal, want.cell_metal);
        endtask

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted 2-D histogram testbench
// Directed deposits and reads at the grid edges, then random items over a
// series of grid settings (extremes, empty grid, clipped sizes, random).
// Items go in with random gaps; every result is checked against the
// scoreboard's own prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import whist_pkg::*;
    import whist_sb_pkg::*;

    localparam int MAX_COLUMNS     = 64;
    localparam int MAX_ROWS        = 64;
    localparam int ITEMS_PER_PHASE = 107;
    localparam int STALL_LIMIT     = 20000;

    typedef struct packed {
        logic [15:0] x_min;
        logic [15:0] x_scale;
        logic [15:0] y_min;
        logic [15:0] y_scale;
        logic [6:0]  cells_x;
        logic [6:0]  cells_y;
    } grid_setup_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    hist_in_t    request   = '0;
    logic        done;
    hist_out_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    hist_scoreboard #(MAX_COLUMNS, MAX_ROWS) sb;
    grid_setup_t setups [$];
    bit          burst;
    int          idle_cycles;

    weighted_2d_histogram #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** weighted_2d_histogram: FAILED **");
            $finish;
        end
    end

    // first coordinate that falls in the given bin
    function automatic logic [15:0] bin_start_coord(logic signed [15:0] lo,
                                                    logic [15:0] scale, int bin);
        int offset;
        offset = (scale == 0) ? 0 : (bin * 65536 + int'(scale) - 1) / int'(scale);
        return 16'(int'(lo) + offset);
    endfunction

    function automatic logic [15:0] pick_coord(logic signed [15:0] lo, logic [15:0] scale,
                                               logic [6:0] cells, int limit);
        int lim;
        int span;
        lim  = (cells < limit) ? int'(cells) : limit;
        span = (scale == 0) ? 65535 : (lim * 65536) / int'(scale) + 2;
        if (span > 65535)
            span = 65535;
        case ($urandom_range(0, 9))
            7: return 16'($urandom);
            8: return 16'(int'(lo) - int'($urandom_range(1, 4)));
            9: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return bin_start_coord(lo, scale, lim);
                    default: return bin_start_coord(lo, scale, lim) - 16'd1;
                endcase
            end
            default: return 16'(int'(lo) + int'($urandom_range(0, span)));
        endcase
    endfunction

    function automatic logic [23:0] pick_weight(int bits);
        logic [23:0] mask;
        mask = 24'((64'd1 << bits) - 64'd1);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return mask;
            default: return 24'($urandom) & mask;
        endcase
    endfunction

    function automatic hist_in_t make_deposit(logic [15:0] x, logic [15:0] y,
                                              logic [23:0] m, logic [15:0] f);
        hist_in_t it;
        it.action         = ACT_DEPOSIT;
        it.x_coord        = x;
        it.y_coord        = y;
        it.mass           = m;
        it.metal_fraction = f;
        it.read_column    = 6'($urandom);
        it.read_row       = 6'($urandom);
        return it;
    endfunction

    function automatic hist_in_t make_read(int col, int row);
        hist_in_t it;
        it = make_deposit(16'($urandom), 16'($urandom), pick_weight(24),
                          16'(pick_weight(16)));
        it.action      = ACT_READ;
        it.read_column = 6'(col);
        it.read_row    = 6'(row);
        return it;
    endfunction

    function automatic hist_in_t random_item();
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 1) == 1)
                return make_read(sb.last_col, sb.last_row);
            return make_read($urandom_range(0, 63), $urandom_range(0, 63));
        end
        return make_deposit(pick_coord(sb.x_min, sb.x_scale, sb.cells_x, MAX_COLUMNS),
                            pick_coord(sb.y_min, sb.y_scale, sb.cells_y, MAX_ROWS),
                            pick_weight(24), 16'(pick_weight(16)));
    endfunction

    task automatic send(hist_in_t it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= it;
        do @(posedge clk); while (busy);
        sb.note_request(it);
    endtask

    // hold off until every outstanding item has answered
    task automatic quiesce();
        start <= 1'b0;
        while (sb.pending_q.size() != 0 || busy)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic apply_setup(grid_setup_t s);
        write_reg(REG_X_MIN, s.x_min);
        write_reg(REG_X_SCALE, s.x_scale);
        write_reg(REG_Y_MIN, s.y_min);
        write_reg(REG_Y_SCALE, s.y_scale);
        write_reg(REG_CELLS_X, {9'($urandom), s.cells_x});
        write_reg(REG_CELLS_Y, {9'($urandom), s.cells_y});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            send(random_item());
        end
    endtask

    // runs on the reset grid
    task automatic run_directed();
        logic [15:0] x_last;
        logic [15:0] y_last;
        logic [15:0] x_lim;
        logic [15:0] y_lim;
        x_last = bin_start_coord(sb.x_min, sb.x_scale, 63);
        y_last = bin_start_coord(sb.y_min, sb.y_scale, 63);
        x_lim  = bin_start_coord(sb.x_min, sb.x_scale, 64);
        y_lim  = bin_start_coord(sb.y_min, sb.y_scale, 64);
        send(make_read(0, 0));
        send(make_read(63, 63));
        send(make_deposit(sb.x_min, sb.y_min, 24'hFF_FFFF, 16'hFFFF));
        send(make_deposit(sb.x_min, sb.y_min, '0, '0));
        send(make_read(0, 0));
        send(make_deposit(sb.x_min - 16'd1, sb.y_min, pick_weight(24), 16'(pick_weight(16))));
        send(make_deposit(sb.x_min, sb.y_min - 16'd1, pick_weight(24), 16'(pick_weight(16))));
        send(make_deposit(16'h8000, 16'h8000, 24'hFF_FFFF, 16'hFFFF));
        send(make_deposit(16'h7FFF, 16'h7FFF, 24'hFF_FFFF, 16'hFFFF));
        send(make_deposit(x_last, y_last, 24'hFF_FFFF, 16'hFFFF));
        send(make_deposit(x_last, y_last, 24'd1, 16'd1));
        send(make_deposit(x_lim, y_last, pick_weight(24), 16'(pick_weight(16))));
        send(make_deposit(x_last, y_lim, pick_weight(24), 16'(pick_weight(16))));
        send(make_deposit(x_lim - 16'd1, y_lim - 16'd1, 24'h80_0000, 16'h8000));
        send(make_read(63, 63));
        send(make_read(0, 63));
        send(make_read(63, 0));
        send(make_read(1, 1));
    endtask

    initial
    begin
        sb = new();
        setups.push_back('{16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 7'd64, 7'd64});
        setups.push_back('{16'h0000, 16'd256, 16'hFC00, 16'd4096, 7'd8, 7'd5});
        setups.push_back('{16'h7FFF, 16'd0, 16'h8000, 16'd1, 7'd1, 7'd1});
        setups.push_back('{16'($urandom), 16'd1638, 16'($urandom), 16'd2730, 7'd0, 7'd127});
        setups.push_back('{16'hFE00, 16'd3000, 16'h0000, 16'd1, 7'd127, 7'd0});
        setups.push_back('{16'hFF00, 16'd1, 16'h0100, 16'hFFFF, 7'd64, 7'd64});
        setups.push_back('{16'hFE00, 16'd1638, 16'h0200, 16'd2730, 7'd64, 7'd64});
        repeat (4)
            setups.push_back('{16'($urandom), 16'($urandom_range(64, 8192)),
                               16'($urandom), 16'($urandom_range(64, 8192)),
                               7'($urandom_range(1, 64)), 7'($urandom_range(1, 64))});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        run_directed();
        run_random(ITEMS_PER_PHASE);
        quiesce();
        foreach (setups[i]) begin
            apply_setup(setups[i]);
            run_random(ITEMS_PER_PHASE);
            quiesce();
        end
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("** weighted_2d_histogram: PASSED **");
        else
            $display("** weighted_2d_histogram: FAILED **");
        $finish;
    end

endmodule
